// File: design/assert_macros.svh
// Assertion macros for the controller core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: design/gdc_pkg.sv
// Codes, widths and reset values for the garage door controller.
package gdc_pkg;

    localparam int TIME_BITS_DEF = 16;
    localparam int CFG_W         = 16;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int IN_DATA_W     = 8;
    localparam int OUT_DATA_W    = 8;

    // input item kinds
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EDGE    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INIT    = 2'd3;

    // door status codes
    localparam logic [STATUS_W-1:0] ST_OPEN    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CLOSED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OPENING = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CLOSING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE     = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] RELAY_RST    = 16'd300;
    localparam logic [CFG_W-1:0] MOVE_RST     = 16'd30000;

    typedef struct packed {
        logic                report;
        logic                led_on;
        logic                relay_on;
        logic                target_open;
        logic [STATUS_W-1:0] door_status;
    } gdc_result_t;

endpackage

// File: design/garage_door_controller_core.sv
// Garage door controller core: door state, relay pulse, move failsafe, debounce.
// The result of each input transfer lands in the output register in the cycle after the transfer.
// Throughput: one item per cycle; the output register is the only stage and
// s_axis_tready stays high while the result slot is empty or being drained.
// Reset (rst_n, async, active low) loads register defaults 50/300/30000 and
// sets the door to unknown with all timers, lamp and relay cleared.
module garage_door_controller_core #(
    parameter int TIME_BITS = gdc_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gdc_pkg::CFG_W-1:0]         cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [gdc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [0] sensor_open, rest zero
    input  logic [gdc_pkg::MODE_W-1:0]        s_axis_tuser,  // [1:0] mode
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [2:0] door_status, [3] target_open, [4] relay_on, [5] led_on, [6] report
    output logic [gdc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    import gdc_pkg::*;

    `include "assert_macros.svh"

    // Compare width wide enough for both the 16-bit registers and the counters.
    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [CMP_W-1:0] TIME_MAX_EXT = CMP_W'(TIME_MAX);

    // configuration registers
    logic [CFG_W-1:0] debounce_reg, relay_pulse_reg, move_timeout_reg;

    // controller state
    logic [STATUS_W-1:0]  door_mode_reg, door_mode_next;
    logic                 target_reg, target_next;
    logic                 last_level_reg, last_level_next;
    logic [TIME_BITS-1:0] since_edge_reg, since_edge_next;
    logic [TIME_BITS-1:0] pulse_left_reg, pulse_left_next;
    logic [TIME_BITS-1:0] move_left_reg, move_left_next;
    logic                 move_running_reg, move_running_next;
    logic                 lamp_reg, lamp_next;

    // result slot
    logic                 out_valid_reg, out_valid_next;
    gdc_result_t          result_reg, result_next;

    logic                 in_fire;
    logic [MODE_W-1:0]    in_mode;
    logic                 in_level;
    logic                 report;
    logic [TIME_BITS-1:0] pulse_load, move_load;
    logic [CMP_W-1:0]     relay_ext, move_ext;
    logic                 debounce_done;

    assign cfg_ready     = 1'b1;
    assign in_mode       = s_axis_tuser;
    assign in_level      = s_axis_tdata[0];
    // a new item fits when the slot is empty or its result leaves this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // loads into the counters saturate at the counter maximum
    assign relay_ext  = CMP_W'(relay_pulse_reg);
    assign move_ext   = CMP_W'(move_timeout_reg);
    assign pulse_load = (relay_ext > TIME_MAX_EXT) ? TIME_MAX : TIME_BITS'(relay_ext);
    assign move_load  = (move_ext > TIME_MAX_EXT) ? TIME_MAX : TIME_BITS'(move_ext);

    // unclamped compare: a debounce value past the counter max blocks all edges
    assign debounce_done = CMP_W'(since_edge_reg) >= CMP_W'(debounce_reg);

    always_comb
    begin
        door_mode_next    = door_mode_reg;
        target_next       = target_reg;
        last_level_next   = last_level_reg;
        since_edge_next   = since_edge_reg;
        pulse_left_next   = pulse_left_reg;
        move_left_next    = move_left_reg;
        move_running_next = move_running_reg;
        lamp_next         = lamp_reg;
        report            = 1'b0;

        case (in_mode)
            MODE_TICK:
            begin
                if (pulse_left_reg != '0)
                    pulse_left_next = pulse_left_reg - 1'b1;
                if (move_running_reg)
                begin
                    if (move_left_reg <= TIME_BITS'(1))
                    begin
                        // failsafe expiry: trust the sensor, lamp untouched
                        move_left_next    = '0;
                        move_running_next = 1'b0;
                        door_mode_next    = in_level ? ST_OPEN : ST_CLOSED;
                        target_next       = in_level;
                        report            = 1'b1;
                    end
                    else
                    begin
                        move_left_next = move_left_reg - 1'b1;
                    end
                end
                if (since_edge_reg != TIME_MAX)
                    since_edge_next = since_edge_reg + 1'b1;
            end
            MODE_REQUEST:
            begin
                if (in_level || door_mode_reg == ST_OPENING)
                    door_mode_next = ST_CLOSING;
                else
                    door_mode_next = ST_OPENING;
                pulse_left_next = pulse_load;
                if (!move_running_reg)
                begin
                    move_left_next    = move_load;
                    move_running_next = 1'b1;
                end
            end
            MODE_EDGE:
            begin
                if (debounce_done && in_level != last_level_reg)
                begin
                    last_level_next = in_level;
                    since_edge_next = '0;
                    lamp_next       = in_level;
                    door_mode_next  = in_level ? ST_OPEN : ST_CLOSED;
                    target_next     = in_level;
                    report          = 1'b1;
                end
            end
            MODE_INIT:
            begin
                last_level_next = in_level;
                lamp_next       = in_level;
                door_mode_next  = in_level ? ST_OPEN : ST_CLOSED;
                target_next     = in_level;
                report          = 1'b1;
            end
            default:
            begin
                report = 1'b0;
            end
        endcase

        result_next.door_status = door_mode_next;
        result_next.target_open = target_next;
        result_next.relay_on    = (pulse_left_next != '0);
        result_next.led_on      = lamp_next;
        result_next.report      = report;

        out_valid_next = in_fire || (out_valid_reg && !m_axis_tready);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= DEBOUNCE_RST;
            relay_pulse_reg  <= RELAY_RST;
            move_timeout_reg <= MOVE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEBOUNCE: debounce_reg     <= cfg_data;
                CFG_RELAY:    relay_pulse_reg  <= cfg_data;
                CFG_MOVE:     move_timeout_reg <= cfg_data;
                default:      ; // writes past the register list are dropped
            endcase
        end
    end

    // controller state advances only on an input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            door_mode_reg    <= ST_UNKNOWN;
            target_reg       <= 1'b0;
            last_level_reg   <= 1'b0;
            since_edge_reg   <= '0;
            pulse_left_reg   <= '0;
            move_left_reg    <= '0;
            move_running_reg <= 1'b0;
            lamp_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                door_mode_reg    <= door_mode_next;
                target_reg       <= target_next;
                last_level_reg   <= last_level_next;
                since_edge_reg   <= since_edge_next;
                pulse_left_reg   <= pulse_left_next;
                move_left_reg    <= move_left_next;
                move_running_reg <= move_running_next;
                lamp_reg         <= lamp_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
            result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(gdc_result_t)){1'b0}}, result_reg};

    // request reloads the relay pulse from the clamped register value
    `ASSERT_NEXT(a_req_loads_pulse, clk, rst_n, in_fire && in_mode == MODE_REQUEST, pulse_left_reg == $past(pulse_load))
    // the failsafe timer only stops on a tick transfer
    `ASSERT_IMPLIES(a_move_stops_on_tick, clk, rst_n, $fell(move_running_reg), $past(in_fire && in_mode == MODE_TICK))
    // an announced state is always a settled one
    `ASSERT_IMPLIES(a_report_settled, clk, rst_n, m_axis_tvalid && result_reg.report, result_reg.door_status == ST_OPEN || result_reg.door_status == ST_CLOSED)

endmodule
